### src/fk_pkg.sv
package fk_pkg;

   // Build-time settings of the datapath.
   localparam int ANGLE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int NUM_JOINTS   = 6;
   localparam int JNT_W        = $clog2(NUM_JOINTS);
   localparam int CORDIC_ITERS = 30;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int REG_W        = 18;
   localparam int CSR_IDX_W    = 3;

   // CORDIC works in Q3.30 with angles in 2^-32 turn units.
   localparam int XY_W = 34;
   localparam int Z_W  = 34;
   localparam longint CORDIC_GAIN = 652032874;

   // Rotation and trig words hold the closed range of plus or minus one.
   localparam int TRIG_W = TRIG_FRAC_BITS + 2;
   localparam int ROT_W  = TRIG_FRAC_BITS + 2;
   localparam int PROD_W = 2 * TRIG_FRAC_BITS + 4;
   localparam int POS_W  = TRIG_FRAC_BITS + 23;

   localparam longint TRIG_ONE       = longint'(1) << TRIG_FRAC_BITS;
   localparam int     TRIG_RND_SH    = 30 - TRIG_FRAC_BITS;
   localparam longint TRIG_RND_HALF  = (TRIG_RND_SH == 0) ? 0 :
                                       (longint'(1) << (TRIG_RND_SH - 1));
   localparam longint FRAC_HALF      = longint'(1) << (TRIG_FRAC_BITS - 1);

   // Output scaling of the rotation to Q1.14.
   localparam int     ROT_SH_R  = (TRIG_FRAC_BITS >= 14) ? TRIG_FRAC_BITS - 14 : 0;
   localparam int     ROT_SH_L  = (TRIG_FRAC_BITS < 14) ? 14 - TRIG_FRAC_BITS : 0;
   localparam longint ROT_HALF  = (ROT_SH_R == 0) ? 0 : (longint'(1) << (ROT_SH_R - 1));
   localparam int     ROT_OUT_W = ROT_W + 6;
   localparam longint ROT_Q14_ONE = 16384;
   localparam longint POS_MAX = 524287;
   localparam longint POS_MIN = -524288;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_D1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_A3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_D4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_D5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_D6 = 3'd5;

   localparam logic signed [REG_W-1:0] RST_D1 = 18'sd5843;
   localparam logic signed [REG_W-1:0] RST_A2 = -18'sd27853;
   localparam logic signed [REG_W-1:0] RST_A3 = -18'sd25703;
   localparam logic signed [REG_W-1:0] RST_D4 = 18'sd7153;
   localparam logic signed [REG_W-1:0] RST_D5 = 18'sd6203;
   localparam logic signed [REG_W-1:0] RST_D6 = 18'sd5394;

   typedef enum logic [1:0] {
      TWIST_ZERO = 2'd0,
      TWIST_POS  = 2'd1,
      TWIST_NEG  = 2'd2
   } twist_type;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [XY_W-1:0]       xy_type;
   typedef logic signed [Z_W-1:0]        ang_type;
   typedef logic signed [TRIG_W-1:0]     trig_type;
   typedef logic signed [ROT_W-1:0]      rot_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [POS_W-1:0]      pos_type;
   typedef logic signed [REG_W-1:0]      len_type;

   typedef struct packed {
      angle_type joint1_angle;
      angle_type joint2_angle;
      angle_type joint3_angle;
      angle_type joint4_angle;
      angle_type joint5_angle;
      angle_type joint6_angle;
   } fk_req_type;

   typedef struct packed {
      logic signed [15:0] rot_row0_col0;
      logic signed [15:0] rot_row0_col1;
      logic signed [15:0] rot_row0_col2;
      logic signed [15:0] rot_row1_col0;
      logic signed [15:0] rot_row1_col1;
      logic signed [15:0] rot_row1_col2;
      logic signed [15:0] rot_row2_col0;
      logic signed [15:0] rot_row2_col1;
      logic signed [15:0] rot_row2_col2;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
   } fk_rsp_type;

   // One CORDIC lane: vector, residual angle and the half-turn fold flag.
   typedef struct packed {
      xy_type  x;
      xy_type  y;
      ang_type z;
      logic    flip;
   } fk_lane_type;

   typedef fk_lane_type [NUM_JOINTS-1:0] fk_lanes_type;

   // What travels down the row of link cells.
   typedef struct packed {
      trig_type [NUM_JOINTS-1:0] ct;
      trig_type [NUM_JOINTS-1:0] st;
      rot_type  [8:0]            rot;
      pos_type  [2:0]            pos;
   } fk_carry_type;

   // Arctangent of 2^-i in 2^-32 turn units.
   function automatic ang_type atan_turn(input logic [ITER_W-1:0] i);
      ang_type r;
      case (i)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Twist of each link: 90, 0, 0, 90, -90 and 0 degrees.
   function automatic twist_type link_twist(input logic [JNT_W-1:0] j);
      twist_type t;
      case (j)
         3'd0:    t = TWIST_POS;
         3'd3:    t = TWIST_POS;
         3'd4:    t = TWIST_NEG;
         default: t = TWIST_ZERO;
      endcase
      return t;
   endfunction

   // Rotation entry to Q1.14, rounded half up and saturated.
   function automatic logic signed [15:0] rot_to_q14(input rot_type r);
      logic signed [ROT_OUT_W-1:0] v;
      logic signed [15:0]          q;
      v = ROT_OUT_W'(r) + ROT_OUT_W'(ROT_HALF);
      v = v >>> ROT_SH_R;
      v = v <<< ROT_SH_L;
      if (v > ROT_Q14_ONE) begin
         q = 16'sd16384;
      end else if (v < -ROT_Q14_ONE) begin
         q = -16'sd16384;
      end else begin
         q = v[15:0];
      end
      return q;
   endfunction

   // Position to 2^-16 m, rounded half up and saturated.
   function automatic logic signed [19:0] pos_to_out(input pos_type p);
      logic signed [POS_W:0] v;
      logic signed [19:0]    q;
      v = (POS_W + 1)'(p) + (POS_W + 1)'(FRAC_HALF);
      v = v >>> TRIG_FRAC_BITS;
      if (v > POS_MAX) begin
         q = 20'sd524287;
      end else if (v < POS_MIN) begin
         q = -20'sd524288;
      end else begin
         q = v[19:0];
      end
      return q;
   endfunction

endpackage

### src/fk_cordic_cell.sv
module fk_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fk_pkg::ITER_W-1:0]   iter,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  fk_pkg::fk_lanes_type        up_lanes,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output fk_pkg::fk_lanes_type        dn_lanes
);
   import fk_pkg::*;

   logic         valid_ff;
   fk_lanes_type lanes_ff;
   fk_lanes_type lanes_in;
   logic         adv;
   ang_type      atan;

   // The cell moves on whenever it is empty or its item is taken.
   assign adv      = !valid_ff || dn_ready;
   assign up_ready = adv;
   assign atan     = atan_turn(iter);

   // One micro-rotation per lane, steered by the sign of the residual angle.
   always_comb begin
      xy_type xs [NUM_JOINTS];
      xy_type ys [NUM_JOINTS];
      for (int j = 0; j < NUM_JOINTS; j++) begin
         xs[j] = up_lanes[j].x >>> iter;
         ys[j] = up_lanes[j].y >>> iter;
         lanes_in[j].flip = up_lanes[j].flip;
         if (!up_lanes[j].z[Z_W-1]) begin
            lanes_in[j].x = up_lanes[j].x - ys[j];
            lanes_in[j].y = up_lanes[j].y + xs[j];
            lanes_in[j].z = up_lanes[j].z - atan;
         end else begin
            lanes_in[j].x = up_lanes[j].x + ys[j];
            lanes_in[j].y = up_lanes[j].y - xs[j];
            lanes_in[j].z = up_lanes[j].z + atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff <= lanes_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_lanes = lanes_ff;

endmodule

### src/fk_link_cell.sv
module fk_link_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [fk_pkg::JNT_W-1:0]   joint,
   input  fk_pkg::len_type            len_a,
   input  fk_pkg::len_type            off_d,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  fk_pkg::fk_carry_type       up_data,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output fk_pkg::fk_carry_type       dn_data
);
   import fk_pkg::*;

   twist_type    twist;
   trig_type     ct;
   trig_type     st;

   // Stage 1: products of the joint trig with the first two columns and of d with the third.
   logic         v1_ff;
   logic         adv1;
   fk_carry_type c1_ff;
   prod_type     pcr0_ff [3];
   prod_type     psr1_ff [3];
   prod_type     pcr1_ff [3];
   prod_type     psr0_ff [3];
   pos_type      pd1_ff  [3];
   rot_type      r2a_ff  [3];

   // Stage 2: rounded and clamped new first column and rotated second one.
   logic         v2_ff;
   logic         adv2;
   fk_carry_type c2_ff;
   rot_type      u_ff    [3];
   rot_type      w_ff    [3];
   rot_type      u_in    [3];
   rot_type      w_in    [3];
   pos_type      pd2_ff  [3];
   rot_type      r2b_ff  [3];

   // Stage 3: position update and column shuffle for the link twist.
   logic         v3_ff;
   logic         adv3;
   fk_carry_type c3_ff;
   fk_carry_type c3_in;

   assign twist = link_twist(joint);
   assign ct    = up_data.ct[joint];
   assign st    = up_data.st[joint];

   assign adv3     = !v3_ff || dn_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign up_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= up_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         c1_ff <= up_data;
         for (int k = 0; k < 3; k++) begin
            pcr0_ff[k] <= PROD_W'(ct) * PROD_W'(up_data.rot[3*k]);
            psr1_ff[k] <= PROD_W'(st) * PROD_W'(up_data.rot[3*k+1]);
            pcr1_ff[k] <= PROD_W'(ct) * PROD_W'(up_data.rot[3*k+1]);
            psr0_ff[k] <= PROD_W'(st) * PROD_W'(up_data.rot[3*k]);
            pd1_ff[k]  <= POS_W'(off_d) * POS_W'(up_data.rot[3*k+2]);
            r2a_ff[k]  <= up_data.rot[3*k+2];
         end
      end
   end

   // Round the sums from Q(2F) to Q(F) half up and clamp to plus or minus one.
   always_comb begin
      logic signed [PROD_W:0] su [3];
      logic signed [PROD_W:0] sw [3];
      for (int k = 0; k < 3; k++) begin
         su[k] = (PROD_W + 1)'(pcr0_ff[k]) + (PROD_W + 1)'(psr1_ff[k])
               + (PROD_W + 1)'(FRAC_HALF);
         sw[k] = (PROD_W + 1)'(pcr1_ff[k]) - (PROD_W + 1)'(psr0_ff[k])
               + (PROD_W + 1)'(FRAC_HALF);
         su[k] = su[k] >>> TRIG_FRAC_BITS;
         sw[k] = sw[k] >>> TRIG_FRAC_BITS;
         if (su[k] > TRIG_ONE) begin
            u_in[k] = ROT_W'(TRIG_ONE);
         end else if (su[k] < -TRIG_ONE) begin
            u_in[k] = ROT_W'(-TRIG_ONE);
         end else begin
            u_in[k] = su[k][ROT_W-1:0];
         end
         if (sw[k] > TRIG_ONE) begin
            w_in[k] = ROT_W'(TRIG_ONE);
         end else if (sw[k] < -TRIG_ONE) begin
            w_in[k] = ROT_W'(-TRIG_ONE);
         end else begin
            w_in[k] = sw[k][ROT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         c2_ff <= c1_ff;
         for (int k = 0; k < 3; k++) begin
            u_ff[k]   <= u_in[k];
            w_ff[k]   <= w_in[k];
            pd2_ff[k] <= pd1_ff[k];
            r2b_ff[k] <= r2a_ff[k];
         end
      end
   end

   // The position gains a*u plus d times the old third column.
   always_comb begin
      pos_type au [3];
      c3_in = c2_ff;
      for (int k = 0; k < 3; k++) begin
         au[k] = POS_W'(len_a) * POS_W'(u_ff[k]);
         c3_in.pos[k]   = c2_ff.pos[k] + au[k] + pd2_ff[k];
         c3_in.rot[3*k] = u_ff[k];
         case (twist)
            TWIST_POS: begin
               c3_in.rot[3*k+1] = r2b_ff[k];
               c3_in.rot[3*k+2] = -w_ff[k];
            end
            TWIST_NEG: begin
               c3_in.rot[3*k+1] = -r2b_ff[k];
               c3_in.rot[3*k+2] = w_ff[k];
            end
            default: begin
               c3_in.rot[3*k+1] = w_ff[k];
               c3_in.rot[3*k+2] = r2b_ff[k];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         c3_ff <= c3_in;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_data  = c3_ff;

endmodule

### src/six_joint_dh_forward_kinematics.sv
// Six-joint forward kinematics with classic Denavit-Hartenberg links. Each item
// carries six binary joint angles and yields one pose: a 3x3 rotation in Q1.14
// and a saturated position in 2^-16 m. The block is a row of cells, one angle
// fold stage, thirty CORDIC cells (one micro-rotation each, all six joints side
// by side), a trig rounding stage, six link cells of three stages each and an
// output register. An item passes through these 51 registers in turn before its
// result shows. A new item is accepted in every cycle; a stall on the result
// side fills the empty stages first and only then holds off the input. The link
// lengths and offsets are read straight from their registers, so the user
// must write them only while the block holds no item; the block itself does
// not enforce this.
module six_joint_dh_forward_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fk_pkg::fk_req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fk_pkg::fk_rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [fk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fk_pkg::REG_W-1:0]          csr_wdata
);
   import fk_pkg::*;

   localparam ang_type Z_QUARTER = Z_W'(longint'(1) << 30);
   localparam ang_type Z_HALF    = Z_W'(longint'(1) << 31);

   // Configuration registers.
   len_type d1_ff, a2_ff, a3_ff, d4_ff, d5_ff, d6_ff;
   len_type len_a [NUM_JOINTS];
   len_type off_d [NUM_JOINTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= RST_D1;
         a2_ff <= RST_A2;
         a3_ff <= RST_A3;
         d4_ff <= RST_D4;
         d5_ff <= RST_D5;
         d6_ff <= RST_D6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_D1:  d1_ff <= csr_wdata;
            CSR_A2:  a2_ff <= csr_wdata;
            CSR_A3:  a3_ff <= csr_wdata;
            CSR_D4:  d4_ff <= csr_wdata;
            CSR_D5:  d5_ff <= csr_wdata;
            CSR_D6:  d6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Lengths and offsets that are not registers are zero.
   always_comb begin
      len_a[0] = '0;    off_d[0] = d1_ff;
      len_a[1] = a2_ff; off_d[1] = '0;
      len_a[2] = a3_ff; off_d[2] = '0;
      len_a[3] = '0;    off_d[3] = d4_ff;
      len_a[4] = '0;    off_d[4] = d5_ff;
      len_a[5] = '0;    off_d[5] = d6_ff;
   end

   // Front stage: widen each angle to a 32-bit turn and fold it by a half turn
   // into the quarter-turn range of the CORDIC.
   angle_type    angle [NUM_JOINTS];
   fk_lanes_type front_in;
   logic         cord_valid [CORDIC_ITERS+1];
   logic         cord_ready [CORDIC_ITERS+1];
   fk_lanes_type cord_lanes [CORDIC_ITERS+1];
   logic         front_valid_ff;
   fk_lanes_type front_ff;
   logic         front_adv;

   assign angle[0] = req_data.joint1_angle;
   assign angle[1] = req_data.joint2_angle;
   assign angle[2] = req_data.joint3_angle;
   assign angle[3] = req_data.joint4_angle;
   assign angle[4] = req_data.joint5_angle;
   assign angle[5] = req_data.joint6_angle;

   always_comb begin
      ang_type z [NUM_JOINTS];
      for (int j = 0; j < NUM_JOINTS; j++) begin
         z[j] = Z_W'($signed({angle[j], {(32 - ANGLE_BITS){1'b0}}}));
         front_in[j].x = XY_W'(CORDIC_GAIN);
         front_in[j].y = '0;
         if (z[j] > Z_QUARTER) begin
            front_in[j].z    = z[j] - Z_HALF;
            front_in[j].flip = 1'b1;
         end else if (z[j] < -Z_QUARTER) begin
            front_in[j].z    = z[j] + Z_HALF;
            front_in[j].flip = 1'b1;
         end else begin
            front_in[j].z    = z[j];
            front_in[j].flip = 1'b0;
         end
      end
   end

   assign front_adv = !front_valid_ff || cord_ready[0];
   assign req_stall = !front_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_adv) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         front_ff <= front_in;
      end
   end

   assign cord_valid[0] = front_valid_ff;
   assign cord_lanes[0] = front_ff;

   // Row of CORDIC cells, one micro-rotation each.
   for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
      fk_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .iter     (ITER_W'(g)),
         .up_valid (cord_valid[g]),
         .up_ready (cord_ready[g]),
         .up_lanes (cord_lanes[g]),
         .dn_valid (cord_valid[g+1]),
         .dn_ready (cord_ready[g+1]),
         .dn_lanes (cord_lanes[g+1])
      );
   end

   // Trig stage: round cos and sin to Q(F), clamp, undo the fold and start
   // the pose from the identity.
   logic         link_valid [NUM_JOINTS+1];
   logic         link_ready [NUM_JOINTS+1];
   fk_carry_type link_data  [NUM_JOINTS+1];
   logic         trig_valid_ff;
   fk_carry_type trig_ff;
   fk_carry_type trig_in;
   logic         trig_adv;

   always_comb begin
      xy_type   xr [NUM_JOINTS];
      xy_type   yr [NUM_JOINTS];
      trig_type xc [NUM_JOINTS];
      trig_type yc [NUM_JOINTS];
      trig_in = '0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         xr[j] = (cord_lanes[CORDIC_ITERS][j].x + XY_W'(TRIG_RND_HALF)) >>> TRIG_RND_SH;
         yr[j] = (cord_lanes[CORDIC_ITERS][j].y + XY_W'(TRIG_RND_HALF)) >>> TRIG_RND_SH;
         if (xr[j] > TRIG_ONE) begin
            xc[j] = TRIG_W'(TRIG_ONE);
         end else if (xr[j] < -TRIG_ONE) begin
            xc[j] = TRIG_W'(-TRIG_ONE);
         end else begin
            xc[j] = xr[j][TRIG_W-1:0];
         end
         if (yr[j] > TRIG_ONE) begin
            yc[j] = TRIG_W'(TRIG_ONE);
         end else if (yr[j] < -TRIG_ONE) begin
            yc[j] = TRIG_W'(-TRIG_ONE);
         end else begin
            yc[j] = yr[j][TRIG_W-1:0];
         end
         trig_in.ct[j] = cord_lanes[CORDIC_ITERS][j].flip ? -xc[j] : xc[j];
         trig_in.st[j] = cord_lanes[CORDIC_ITERS][j].flip ? -yc[j] : yc[j];
      end
      trig_in.rot[0] = ROT_W'(TRIG_ONE);
      trig_in.rot[4] = ROT_W'(TRIG_ONE);
      trig_in.rot[8] = ROT_W'(TRIG_ONE);
   end

   assign trig_adv                 = !trig_valid_ff || link_ready[0];
   assign cord_ready[CORDIC_ITERS] = trig_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
      end else if (trig_adv) begin
         trig_valid_ff <= cord_valid[CORDIC_ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (trig_adv) begin
         trig_ff <= trig_in;
      end
   end

   assign link_valid[0] = trig_valid_ff;
   assign link_data[0]  = trig_ff;

   // Row of link cells, one per joint.
   for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_link
      fk_link_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .joint    (JNT_W'(g)),
         .len_a    (len_a[g]),
         .off_d    (off_d[g]),
         .up_valid (link_valid[g]),
         .up_ready (link_ready[g]),
         .up_data  (link_data[g]),
         .dn_valid (link_valid[g+1]),
         .dn_ready (link_ready[g+1]),
         .dn_data  (link_data[g+1])
      );
   end

   // Output register: scale the pose to the result formats.
   logic         rsp_valid_ff;
   fk_rsp_type   rsp_ff;
   fk_rsp_type   rsp_in;
   logic         out_adv;
   fk_carry_type last;

   assign last = link_data[NUM_JOINTS];

   always_comb begin
      rsp_in.rot_row0_col0 = rot_to_q14(last.rot[0]);
      rsp_in.rot_row0_col1 = rot_to_q14(last.rot[1]);
      rsp_in.rot_row0_col2 = rot_to_q14(last.rot[2]);
      rsp_in.rot_row1_col0 = rot_to_q14(last.rot[3]);
      rsp_in.rot_row1_col1 = rot_to_q14(last.rot[4]);
      rsp_in.rot_row1_col2 = rot_to_q14(last.rot[5]);
      rsp_in.rot_row2_col0 = rot_to_q14(last.rot[6]);
      rsp_in.rot_row2_col1 = rot_to_q14(last.rot[7]);
      rsp_in.rot_row2_col2 = rot_to_q14(last.rot[8]);
      rsp_in.pos_x         = pos_to_out(last.pos[0]);
      rsp_in.pos_y         = pos_to_out(last.pos[1]);
      rsp_in.pos_z         = pos_to_out(last.pos[2]);
   end

   assign out_adv                = !rsp_valid_ff || !rsp_stall;
   assign link_ready[NUM_JOINTS] = out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= link_valid[NUM_JOINTS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/fk_checker.sv
module fk_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input fk_pkg::fk_req_type            req_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input fk_pkg::fk_rsp_type            rsp_data
);
   import fk_pkg::*;

   // Reset empties the pipeline, so no result shows in the cycle after it.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled input item stays offered and keeps its value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled input item changed");

   // A stalled result stays and keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Diagonal rotation entries are saturated to plus or minus one in Q1.14.
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.rot_row0_col0 <= 16'sd16384 && rsp_data.rot_row0_col0 >= -16'sd16384 &&
         rsp_data.rot_row1_col1 <= 16'sd16384 && rsp_data.rot_row1_col1 >= -16'sd16384 &&
         rsp_data.rot_row2_col2 <= 16'sd16384 && rsp_data.rot_row2_col2 >= -16'sd16384)
      else $error("rotation entry out of range");

endmodule

bind six_joint_dh_forward_kinematics fk_checker u_fk_checker (.*);
